@@ hdl/nqts_pkg.sv @@
// ----------------------------------------------------------------------------
// nqts_pkg
// Shared types and constants of the note queue tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package nqts_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int STEP_W      = 10;
    localparam int QCOUNT_W    = 8;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);
    localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;

    // Item codes on the action field
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // One queue entry as stored in the note memory
    typedef struct packed {
        logic              sweep_up;
        logic              sweep_enable;
        logic [DUR_W-1:0]  duration;
        logic [FREQ_W-1:0] frequency;
    } note_t;

    localparam int NOTE_W = $bits(note_t);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/nqts_ram.sv @@
// ----------------------------------------------------------------------------
// nqts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nqts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/note_queue_tone_sequencer.sv @@
// Flow: an accepted word is captured together with a read of the head entry
//   of the note memory; in ST_EXEC it commits into the result register once
//   that register is free, and out_valid is set. A new word is not taken until
//   the previous one has committed: in_stall stays high in ST_EXEC.
// Reset: rst_n clears the FSM, pointers, counters and tone state at once; the
//   note memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// note_queue_tone_sequencer
// Buzzer tone sequencer: a note FIFO in RAM, popped when a note ends and swept on ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module note_queue_tone_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // configuration: sweep step in hertz
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nqts_pkg::STEP_W-1:0]   cfg_data,

    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [nqts_pkg::FREQ_W-1:0]   frequency,
    input  wire logic [nqts_pkg::DUR_W-1:0]    duration,
    input  wire logic                          sweep_enable,
    input  wire logic                          sweep_up,

    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               tone_on,
    output logic [nqts_pkg::FREQ_W-1:0]        tone_frequency,
    output logic                               frequency_written,
    output logic                               note_accepted,
    output logic [nqts_pkg::QCOUNT_W-1:0]      queue_count
);

    import nqts_pkg::*;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic               accept;
    logic               commit;

    // Item captured at acceptance, held while the memory read completes
    logic               item_action_reg;
    note_t              item_note_reg;

    // Queue and tone state
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   waiting_reg, waiting_next;
    logic [FREQ_W-1:0]  cur_freq_reg, cur_freq_next;
    logic [DUR_W-1:0]   cur_dur_reg, cur_dur_next;
    logic [DUR_W-1:0]   elapsed_reg, elapsed_next;
    logic               cur_sweep_en_reg, cur_sweep_en_next;
    logic               cur_sweep_up_reg, cur_sweep_up_next;
    logic               tone_reg, tone_next;
    logic [STEP_W-1:0]  step_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_tone_reg;
    logic [FREQ_W-1:0]  out_freq_reg;
    logic               out_written_reg;
    logic               out_accepted_reg;
    logic [QCOUNT_W-1:0] out_count_reg;

    // Memory ports
    logic               ram_wr_en;
    logic [NOTE_W-1:0]  ram_rd_data;
    note_t              head_note;

    // Datapath intermediates
    logic               enq_ok;
    logic               written;
    logic [FREQ_W-1:0]  f0;
    logic [DUR_W-1:0]   d0;
    logic [DUR_W-1:0]   e0;
    logic [DUR_W-1:0]   e1;
    logic               sw_en0;
    logic               sw_up0;
    logic [FREQ_W:0]    f_up;

    // ------------------------------------------------------------------
    // Note memory: read the head entry on every accepted word, write
    // the tail entry when an enqueue commits. A write always lands at
    // an edge before the next read is issued, so no forwarding is needed.
    // ------------------------------------------------------------------
    nqts_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (item_note_reg),
        .rd_en   (accept),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign head_note = note_t'(ram_rd_data);

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while the previous result still waits downstream
                if (!(out_valid_reg && out_stall))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall = 1'b1;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_EXEC:
            begin
                commit = !(out_valid_reg && out_stall);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Item datapath: pop on note end, count, sweep with saturation
    // ------------------------------------------------------------------
    always_comb
    begin
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        waiting_next      = waiting_reg;
        tone_next         = tone_reg;
        enq_ok            = 1'b0;
        written           = 1'b0;
        f0                = cur_freq_reg;
        d0                = cur_dur_reg;
        e0                = elapsed_reg;
        e1                = elapsed_reg;
        sw_en0            = cur_sweep_en_reg;
        sw_up0            = cur_sweep_up_reg;
        f_up              = '0;
        cur_freq_next     = cur_freq_reg;
        cur_dur_next      = cur_dur_reg;
        elapsed_next      = elapsed_reg;
        cur_sweep_en_next = cur_sweep_en_reg;
        cur_sweep_up_next = cur_sweep_up_reg;

        if (item_action_reg == ACT_ENQUEUE)
        begin
            // drop the note when the queue is full
            if (waiting_reg < CNT_W'(QUEUE_DEPTH))
            begin
                enq_ok       = 1'b1;
                wr_ptr_next  = ptr_advance(wr_ptr_reg);
                waiting_next = waiting_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (elapsed_reg >= cur_dur_reg)
            begin
                if (waiting_reg != '0)
                begin
                    // take the head note and switch the tone on
                    f0           = head_note.frequency;
                    d0           = head_note.duration;
                    sw_en0       = head_note.sweep_enable;
                    sw_up0       = head_note.sweep_up;
                    e0           = '0;
                    rd_ptr_next  = ptr_advance(rd_ptr_reg);
                    waiting_next = waiting_reg - CNT_W'(1);
                    tone_next    = 1'b1;
                end
                else
                begin
                    // queue empty: go silent, keep the last frequency
                    d0        = '0;
                    tone_next = 1'b0;
                end
            end

            e1 = e0;
            if (d0 != '0)
            begin
                e1 = e0 + DUR_W'(1);
                if (e1 < d0)
                begin
                    if (sw_en0)
                    begin
                        if (sw_up0)
                        begin
                            f_up = {1'b0, f0} + (FREQ_W + 1)'(step_reg);
                            f0   = f_up[FREQ_W] ? FREQ_MAX : f_up[FREQ_W-1:0];
                        end
                        else
                        begin
                            f0 = (f0 > FREQ_W'(step_reg)) ? f0 - FREQ_W'(step_reg)
                                                          : '0;
                        end
                    end
                    written = 1'b1;
                end
            end

            cur_freq_next     = f0;
            cur_dur_next      = d0;
            elapsed_next      = e1;
            cur_sweep_en_next = sw_en0;
            cur_sweep_up_next = sw_up0;
        end
    end

    assign ram_wr_en = commit && enq_ok;

    // valid drops once the result is taken, rises when an item commits
    assign out_valid_next = commit ? 1'b1 : (out_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            waiting_reg      <= '0;
            cur_freq_reg     <= '0;
            cur_dur_reg      <= '0;
            elapsed_reg      <= '0;
            cur_sweep_en_reg <= 1'b0;
            cur_sweep_up_reg <= 1'b0;
            tone_reg         <= 1'b0;
            step_reg         <= STEP_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
            if (commit)
            begin
                rd_ptr_reg       <= rd_ptr_next;
                wr_ptr_reg       <= wr_ptr_next;
                waiting_reg      <= waiting_next;
                cur_freq_reg     <= cur_freq_next;
                cur_dur_reg      <= cur_dur_next;
                elapsed_reg      <= elapsed_next;
                cur_sweep_en_reg <= cur_sweep_en_next;
                cur_sweep_up_reg <= cur_sweep_up_next;
                tone_reg         <= tone_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: capture on accept, load result on commit
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_action_reg            <= action;
            item_note_reg.frequency    <= frequency;
            item_note_reg.duration     <= duration;
            item_note_reg.sweep_enable <= sweep_enable;
            item_note_reg.sweep_up     <= sweep_up;
        end
        if (commit)
        begin
            out_tone_reg     <= tone_next;
            out_freq_reg     <= cur_freq_next;
            out_written_reg  <= written;
            out_accepted_reg <= enq_ok;
            out_count_reg    <= QCOUNT_W'(waiting_next);
        end
    end

    assign out_valid         = out_valid_reg;
    assign tone_on           = out_tone_reg;
    assign tone_frequency    = out_freq_reg;
    assign frequency_written = out_written_reg;
    assign note_accepted     = out_accepted_reg;
    assign queue_count       = out_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && out_stall) |=> state_reg == ST_EXEC)
        else $error("item committed while result register was stalled");

    a_exclusive_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_written_reg && out_accepted_reg))
        else $error("result marks both a write and an enqueue");

    a_new_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without a committed item");
`endif

endmodule

`default_nettype wire

@@ test/note_queue_tone_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// note_queue_tone_sequencer_test
// Self-checking bench: scripted notes and ticks, then random note bursts,
// queue fills and sweep-step changes, then the closing rows, each result word checked in order.
// ----------------------------------------------------------------------------
module note_queue_tone_sequencer_test;

    import nqts_pkg::*;

    // One input word as it appears on the payload ports
    typedef struct packed {
        logic              action;
        logic [FREQ_W-1:0] frequency;
        logic [DUR_W-1:0]  duration;
        logic              sweep_enable;
        logic              sweep_up;
    } note_cmd_t;

    // One result word as it appears on the output ports
    typedef struct packed {
        logic                tone_on;
        logic [FREQ_W-1:0]   tone_frequency;
        logic                frequency_written;
        logic                note_accepted;
        logic [QCOUNT_W-1:0] queue_count;
    } tone_t;

    typedef enum logic {
        ROW_WORD,
        ROW_STEP
    } row_kind_t;

    // One line of the scripted part: a word or a sweep-step write.
    // Rows marked closing run after the random part.
    typedef struct packed {
        row_kind_t         kind;
        logic              closing;
        note_cmd_t         cmd;
        logic [STEP_W-1:0] step;
        logic              typed;
        tone_t             want;
    } script_row_t;

    localparam note_cmd_t NO_CMD  = '0;
    localparam tone_t     NO_TONE = '0;

    localparam int RANDOM_WORDS = 1000;
    localparam int FILL_ROOM    = 400;
    localparam int SCRIPT_ROWS  = 31;

    // Opening rows check reset behavior, saturation at both ends, the zero-length
    // note, silence on an empty queue and the reset sweep step by hand. The rows
    // after the first step write lean on the tone predictor.
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // tick straight after reset: silent, nothing queued
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b0, 16'd0, 1'b0, 1'b0, 8'd0}},
        // queue four notes: top frequency sweeping up, zero sweeping down,
        // a zero-length note, and one that shows the reset sweep step
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd65535, 16'd3, 1'b1, 1'b1}, 10'd0, 1'b1,
          '{1'b0, 16'd0, 1'b0, 1'b1, 8'd1}},
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd0, 16'd3, 1'b1, 1'b0}, 10'd0, 1'b1,
          '{1'b0, 16'd0, 1'b0, 1'b1, 8'd2}},
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd1000, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b0, 16'd0, 1'b0, 1'b1, 8'd3}},
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd12345, 16'd2, 1'b1, 1'b1}, 10'd0, 1'b1,
          '{1'b0, 16'd0, 1'b0, 1'b1, 8'd4}},
        // upward sweep pinned at the top, no write on the last tick
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd65535, 1'b1, 1'b0, 8'd3}},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd65535, 1'b1, 1'b0, 8'd3}},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd65535, 1'b0, 1'b0, 8'd3}},
        // downward sweep pinned at zero
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd0, 1'b1, 1'b0, 8'd2}},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd0, 1'b1, 1'b0, 8'd2}},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd0, 1'b0, 1'b0, 8'd2}},
        // zero-length note: tone on, nothing counted
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd1000, 1'b0, 1'b0, 8'd1}},
        // next tick pops again; reset step of 10 Hz applied
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd12355, 1'b1, 1'b0, 8'd0}},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b1, 16'd12355, 1'b0, 1'b0, 8'd0}},
        // empty queue at note end: silent, frequency kept
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b1,
          '{1'b0, 16'd12355, 1'b0, 1'b0, 8'd0}},
        // widest step: saturate both ways from near each end of the range
        '{ROW_STEP, 1'b0, NO_CMD, 10'd1023, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd100, 16'd2, 1'b1, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd65000, 16'd2, 1'b1, 1'b1}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        // zero step: sweep enabled but frequency holds
        '{ROW_STEP, 1'b0, NO_CMD, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_ENQUEUE, 16'd40000, 16'd3, 1'b1, 1'b1}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b0, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        // closing: the longest note with every field bit set; it never ends
        '{ROW_WORD, 1'b1, '{ACT_ENQUEUE, 16'd65535, 16'd65535, 1'b1, 1'b1}, 10'd0, 1'b0,
          NO_TONE},
        '{ROW_WORD, 1'b1, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE},
        '{ROW_WORD, 1'b1, '{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 10'd0, 1'b0, NO_TONE}
    };

    logic clk;
    logic rst_n;

    logic              cfg_valid;
    logic              cfg_ready;
    logic [STEP_W-1:0] cfg_data;

    logic              in_valid;
    logic              in_stall;
    logic              action;
    logic [FREQ_W-1:0] frequency;
    logic [DUR_W-1:0]  duration;
    logic              sweep_enable;
    logic              sweep_up;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                tone_on;
    logic [FREQ_W-1:0]   tone_frequency;
    logic                frequency_written;
    logic                note_accepted;
    logic [QCOUNT_W-1:0] queue_count;

    note_queue_tone_sequencer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .frequency         (frequency),
        .duration          (duration),
        .sweep_enable      (sweep_enable),
        .sweep_up          (sweep_up),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tone_on           (tone_on),
        .tone_frequency    (tone_frequency),
        .frequency_written (frequency_written),
        .note_accepted     (note_accepted),
        .queue_count       (queue_count)
    );

    // Predicted sequencer state, updated once per accepted word
    note_t             queued_notes[$];
    logic [FREQ_W-1:0] play_freq     = '0;
    logic [DUR_W-1:0]  play_dur      = '0;
    logic [DUR_W-1:0]  play_elapsed  = '0;
    logic              play_sweep_en = 1'b0;
    logic              play_sweep_up = 1'b0;
    logic              play_on       = 1'b0;
    logic [STEP_W-1:0] sweep_step    = STEP_RESET;

    tone_t tone_results_due[$];
    int    mismatch_count = 0;
    int    words_sent     = 0;
    int    burst_left     = 0;

    int         stall_hold  = 0;
    int         stall_mode  = 0;
    logic [2:0] stall_phase = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run the sequencer one word ahead: push or pop the note queue, count the
    // tick, sweep with saturation, and return the result word it must produce.
    function automatic tone_t tone_after_word(input note_cmd_t w);
        tone_t       r;
        note_t       n;
        logic [16:0] raised;
        r = '0;
        if (w.action == ACT_ENQUEUE)
        begin
            // full queue: drop the note, accepted stays low
            if (queued_notes.size() < QUEUE_DEPTH)
            begin
                n.frequency    = w.frequency;
                n.duration     = w.duration;
                n.sweep_enable = w.sweep_enable;
                n.sweep_up     = w.sweep_up;
                queued_notes.push_back(n);
                r.note_accepted = 1'b1;
            end
        end
        else
        begin
            // note ran out: advance to the next one or go silent
            if (play_elapsed >= play_dur)
            begin
                if (queued_notes.size() != 0)
                begin
                    n             = queued_notes.pop_front();
                    play_freq     = n.frequency;
                    play_dur      = n.duration;
                    play_sweep_en = n.sweep_enable;
                    play_sweep_up = n.sweep_up;
                    play_elapsed  = '0;
                    play_on       = 1'b1;
                end
                else
                begin
                    play_dur = '0;
                    play_on  = 1'b0;
                end
            end
            if (play_dur != 0)
            begin
                play_elapsed = play_elapsed + 1'b1;
                // the tick that reaches the duration neither sweeps nor writes
                if (play_elapsed < play_dur)
                begin
                    if (play_sweep_en)
                    begin
                        if (play_sweep_up)
                        begin
                            raised    = {1'b0, play_freq} + sweep_step;
                            play_freq = raised[16] ? FREQ_MAX : raised[FREQ_W-1:0];
                        end
                        else
                        begin
                            play_freq = (play_freq > sweep_step) ? play_freq - sweep_step : '0;
                        end
                    end
                    r.frequency_written = 1'b1;
                end
            end
        end
        r.tone_on        = play_on;
        r.tone_frequency = play_freq;
        r.queue_count    = QCOUNT_W'(queued_notes.size());
        return r;
    endfunction

    // Random note: frequencies favor both ends of the range, durations stay short
    // so notes turn over quickly; a short_notes fill keeps the drain cheap.
    function automatic note_cmd_t random_note(input bit short_notes);
        note_cmd_t w;
        w.action = ACT_ENQUEUE;
        case ($urandom_range(0, 3))
            0:       w.frequency = FREQ_W'($urandom_range(0, 40));
            1:       w.frequency = FREQ_W'($urandom_range(65490, 65535));
            default: w.frequency = FREQ_W'($urandom);
        endcase
        if (short_notes)
            w.duration = DUR_W'($urandom_range(0, 2));
        else if ($urandom_range(0, 7) == 0)
            w.duration = DUR_W'($urandom_range(9, 48));
        else
            w.duration = DUR_W'($urandom_range(0, 8));
        w.sweep_enable = 1'($urandom);
        w.sweep_up     = 1'($urandom);
        return w;
    endfunction

    // Present one word, hold it until the block takes it, then log what it
    // must produce. Between bursts drop valid for a random gap.
    task automatic send_word(input note_cmd_t w, input bit typed, input tone_t want);
        tone_t predicted;
        in_valid     <= 1'b1;
        action       <= w.action;
        frequency    <= w.frequency;
        duration     <= w.duration;
        sweep_enable <= w.sweep_enable;
        sweep_up     <= w.sweep_up;
        do @(posedge clk); while (in_stall);
        predicted = tone_after_word(w);
        tone_results_due.push_back(typed ? want : predicted);
        words_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Drop valid and hold off until every result word is back, plus a margin for the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        while (tone_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sweep_step(input logic [STEP_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        sweep_step  = value;
    endtask

    task automatic run_script(input bit closing);
        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (SCRIPT[i].closing == closing)
            begin
                if (SCRIPT[i].kind == ROW_STEP)
                    write_sweep_step(SCRIPT[i].step);
                else
                    send_word(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].want);
            end
        end
    endtask

    // One random phase: queue a few notes (or fill the queue past full), then
    // tick through roughly what is queued, with stray enqueues mixed in.
    task automatic play_episode(input bit fill);
        int        n_notes;
        int        n_ticks;
        int        backlog;
        note_cmd_t w;
        if (fill)
            n_notes = QUEUE_DEPTH - queued_notes.size() + $urandom_range(2, 6);
        else
            n_notes = $urandom_range(0, 6);
        for (int i = 0; i < n_notes; i++)
            send_word(random_note(fill), 1'b0, NO_TONE);

        // ticks needed to play out the current note and everything queued
        backlog = (play_elapsed < play_dur) ? int'(play_dur - play_elapsed) : 0;
        foreach (queued_notes[i])
            backlog += (queued_notes[i].duration == 0) ? 1 : int'(queued_notes[i].duration);
        n_ticks = fill ? backlog + 2 : $urandom_range(backlog / 2, backlog + 3);

        for (int i = 0; i < n_ticks; i++)
        begin
            w = random_note(1'b0);
            if ($urandom_range(0, 11) != 0)
                w.action = ACT_TICK;
            send_word(w, 1'b0, NO_TONE);
        end
    endtask

    // Receiver stall: switch among free-flowing, sparse random, a fixed
    // 3-of-8 pattern and heavy random stalling, holding each mode for a random span.
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(16, 160);
        end
        else
        begin
            stall_hold <= stall_hold - 1;
        end
        stall_phase <= stall_phase + 1'b1;
        case (stall_mode)
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= (stall_phase < 3'd3);
            3:       out_stall <= ($urandom_range(0, 5) != 0);
            default: out_stall <= 1'b0;
        endcase
    end

    // Compare each accepted result word with the oldest one due
    always @(posedge clk)
    begin : check_tone
        tone_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tone_results_due.size() == 0)
            begin
                $error("result word with none due: tone_frequency %0d", tone_frequency);
                mismatch_count++;
            end
            else
            begin
                due = tone_results_due.pop_front();
                if (tone_on !== due.tone_on)
                begin
                    $error("tone_on: expected %0d, got %0d", due.tone_on, tone_on);
                    mismatch_count++;
                end
                if (tone_frequency !== due.tone_frequency)
                begin
                    $error("tone_frequency: expected %0d, got %0d",
                           due.tone_frequency, tone_frequency);
                    mismatch_count++;
                end
                if (frequency_written !== due.frequency_written)
                begin
                    $error("frequency_written: expected %0d, got %0d",
                           due.frequency_written, frequency_written);
                    mismatch_count++;
                end
                if (note_accepted !== due.note_accepted)
                begin
                    $error("note_accepted: expected %0d, got %0d",
                           due.note_accepted, note_accepted);
                    mismatch_count++;
                end
                if (queue_count !== due.queue_count)
                begin
                    $error("queue_count: expected %0d, got %0d", due.queue_count, queue_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int                episode;
        int                step_round;
        int                first_random;
        logic [STEP_W-1:0] next_step;
        episode    = 0;
        step_round = 0;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        action       <= ACT_TICK;
        frequency    <= '0;
        duration     <= '0;
        sweep_enable <= 1'b0;
        sweep_up     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_script(1'b0);

        // Random phases; change the sweep step now and then, cycling through
        // both extremes, a small step, a random one and the reset value.
        // Skip a queue fill when too few words remain for it.
        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS)
        begin
            if (episode % 7 == 6)
            begin
                case (step_round % 5)
                    0:       next_step = STEP_W'(1023);
                    1:       next_step = STEP_W'(1);
                    2:       next_step = STEP_W'($urandom_range(0, 1023));
                    3:       next_step = '0;
                    default: next_step = STEP_RESET;
                endcase
                write_sweep_step(next_step);
                step_round++;
            end
            play_episode(episode % 25 == 5 &&
                         words_sent - first_random < RANDOM_WORDS - FILL_ROOM);
            episode++;
        end

        // Pause until the block is idle, play out whatever is left, then
        // start the never-ending note last of all.
        settle();
        while (queued_notes.size() != 0 || play_elapsed < play_dur)
            send_word('{ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, NO_TONE);
        run_script(1'b1);
        settle();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && tone_results_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard, well beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
